@@ rtl/core/sst_pkg.sv @@
// Shared types, constants and the segment pattern table for the time scanner.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    // Frame count per refresh and the widths that follow from it.
    localparam int DIGIT_COUNT = 8;
    localparam int FRAME_W     = $clog2(DIGIT_COUNT);
    localparam int IDX_W       = 4;

    // Pattern indexes that are not decimal digits.
    localparam logic [IDX_W-1:0] DASH_INDEX = 4'd10;
    localparam logic [IDX_W-1:0] DOT_INDEX  = 4'd11;
    localparam logic [IDX_W-1:0] BLANK_INDEX = 4'd12;

    // Active-low segment patterns.
    localparam logic [7:0] SEG_0     = 8'hc0;
    localparam logic [7:0] SEG_1     = 8'hf9;
    localparam logic [7:0] SEG_2     = 8'ha4;
    localparam logic [7:0] SEG_3     = 8'hb0;
    localparam logic [7:0] SEG_4     = 8'h99;
    localparam logic [7:0] SEG_5     = 8'h92;
    localparam logic [7:0] SEG_6     = 8'h82;
    localparam logic [7:0] SEG_7     = 8'hf8;
    localparam logic [7:0] SEG_8     = 8'h80;
    localparam logic [7:0] SEG_9     = 8'h90;
    localparam logic [7:0] SEG_DASH  = 8'hbf;
    localparam logic [7:0] SEG_DOT   = 8'h7f;
    localparam logic [7:0] SEG_BLANK = 8'hff;
    localparam logic [7:0] DOT_MASK  = 8'h7f;

    // Select pattern of the first frame.
    localparam logic [DIGIT_COUNT-1:0] FIRST_SELECT = 8'h80;

    // Display format carried by each request.
    typedef enum logic {
        MODE_CLOCK = 1'b0,
        MODE_WATCH = 1'b1
    } sst_mode_t;

    typedef logic [IDX_W-1:0] sst_idx_t;

    // One classified request: a pattern index and a dot flag per frame.
    typedef struct packed {
        sst_idx_t [DIGIT_COUNT-1:0] idx;
        logic [DIGIT_COUNT-1:0]     dot;
    } sst_entry_t;

    // Pattern table lookup; unused codes show blank.
    function automatic logic [7:0] seg_pattern(input sst_idx_t idx);
        logic [7:0] pat;
        unique case (idx)
            4'd0:        pat = SEG_0;
            4'd1:        pat = SEG_1;
            4'd2:        pat = SEG_2;
            4'd3:        pat = SEG_3;
            4'd4:        pat = SEG_4;
            4'd5:        pat = SEG_5;
            4'd6:        pat = SEG_6;
            4'd7:        pat = SEG_7;
            4'd8:        pat = SEG_8;
            4'd9:        pat = SEG_9;
            DASH_INDEX:  pat = SEG_DASH;
            DOT_INDEX:   pat = SEG_DOT;
            BLANK_INDEX: pat = SEG_BLANK;
            default:     pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sst_front.sv @@
// Front end: accepts refresh requests and splits the time into pattern indexes.
`timescale 1ns / 1ps
`default_nettype none

module sst_front
    import sst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       cmd,
    input  wire logic [6:0] hours,
    input  wire logic [5:0] minutes,
    input  wire logic [5:0] seconds,
    input  wire logic [9:0] milliseconds,
    output logic            wr_valid,
    output sst_entry_t      wr_data,
    input  wire logic       wr_ready
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_cmd_reg;
    logic [6:0] s1_hours_reg;
    logic [5:0] s1_min_reg;
    logic [5:0] s1_sec_reg;
    logic [9:0] s1_ms_reg;
    logic [6:0] s1_msq_reg;

    logic        accept;
    logic [17:0] ms_prod;

    logic [13:0] sec_prod;
    logic [2:0]  sec_tens;
    logic [5:0]  sec_tens10;
    logic [5:0]  sec_diff;
    logic [13:0] min_prod;
    logic [2:0]  min_tens;
    logic [5:0]  min_tens10;
    logic [5:0]  min_diff;
    logic [14:0] hr_prod;
    logic [3:0]  hr_tens;
    logic [6:0]  hr_tens10;
    logic [6:0]  hr_diff;
    logic [9:0]  ms_q10;
    logic [9:0]  ms_diff;
    logic [14:0] msq_prod;
    logic [3:0]  ms_hund_raw;
    logic [6:0]  ms_hund10;
    logic [6:0]  msq_diff;
    logic [3:0]  ms_hund;

    // A request is taken whenever the first stage is free or drains this cycle.
    assign full   = s1_valid_reg && !wr_ready;
    assign accept = push && !full;

    // Tens of milliseconds: multiply by the reciprocal of ten, exact below 1029.
    assign ms_prod = 18'(milliseconds) * 18'd205;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (wr_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Stage one valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= cmd;
            s1_hours_reg <= hours;
            s1_min_reg   <= minutes;
            s1_sec_reg   <= seconds;
            s1_ms_reg    <= milliseconds;
            s1_msq_reg   <= ms_prod[17:11];
        end
    end

    // Decimal split of seconds, minutes and hours.
    always_comb
    begin
        sec_prod   = 14'(s1_sec_reg) * 14'd205;
        sec_tens   = sec_prod[13:11];
        sec_tens10 = {sec_tens, 3'b000} + {2'b00, sec_tens, 1'b0};
        sec_diff   = s1_sec_reg - sec_tens10;

        min_prod   = 14'(s1_min_reg) * 14'd205;
        min_tens   = min_prod[13:11];
        min_tens10 = {min_tens, 3'b000} + {2'b00, min_tens, 1'b0};
        min_diff   = s1_min_reg - min_tens10;

        hr_prod    = 15'(s1_hours_reg) * 15'd205;
        hr_tens    = hr_prod[14:11];
        hr_tens10  = {hr_tens, 3'b000} + {2'b00, hr_tens, 1'b0};
        hr_diff    = s1_hours_reg - hr_tens10;
    end

    // Decimal split of milliseconds from the registered tens count.
    always_comb
    begin
        ms_q10      = {s1_msq_reg, 3'b000} + {2'b00, s1_msq_reg, 1'b0};
        ms_diff     = s1_ms_reg - ms_q10;
        msq_prod    = 15'(s1_msq_reg) * 15'd205;
        ms_hund_raw = msq_prod[14:11];
        ms_hund10   = {ms_hund_raw, 3'b000} + {2'b00, ms_hund_raw, 1'b0};
        msq_diff    = s1_msq_reg - ms_hund10;
        ms_hund     = (ms_hund_raw >= 4'd10) ? (ms_hund_raw - 4'd10) : ms_hund_raw;
    end

    // Frame order for each display format.
    always_comb
    begin
        wr_valid = s1_valid_reg;
        case (sst_mode_t'(s1_cmd_reg))
            MODE_WATCH:
            begin
                wr_data.idx[0] = ms_diff[3:0];
                wr_data.idx[1] = msq_diff[3:0];
                wr_data.idx[2] = ms_hund;
                wr_data.idx[3] = sec_diff[3:0];
                wr_data.idx[4] = {1'b0, sec_tens};
                wr_data.idx[5] = min_diff[3:0];
                wr_data.idx[6] = {1'b0, min_tens};
                wr_data.idx[7] = hr_diff[3:0];
                wr_data.dot    = 8'b1010_1000;
            end
            default:
            begin
                wr_data.idx[0] = sec_diff[3:0];
                wr_data.idx[1] = {1'b0, sec_tens};
                wr_data.idx[2] = DASH_INDEX;
                wr_data.idx[3] = min_diff[3:0];
                wr_data.idx[4] = {1'b0, min_tens};
                wr_data.idx[5] = DASH_INDEX;
                wr_data.idx[6] = hr_diff[3:0];
                wr_data.idx[7] = hr_tens;
                wr_data.dot    = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/sst_queue.sv @@
// Short queue of classified requests between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module sst_queue
    import sst_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire sst_entry_t wr_data,
    output logic            wr_ready,
    input  wire logic       rd_en,
    output sst_entry_t      rd_data,
    output logic            rd_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    sst_entry_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != DEPTH_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sst_back.sv @@
// Back end: scans the eight frames of the head request into the result register.
`timescale 1ns / 1ps
`default_nettype none

module sst_back
    import sst_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sst_entry_t             entry,
    input  wire logic                   entry_valid,
    output logic                        entry_done,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [DIGIT_COUNT-1:0]      digit_select,
    output logic [7:0]                  segments,
    output logic                        last_digit
);

    localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(DIGIT_COUNT - 1);

    logic [FRAME_W-1:0]     frame_reg;
    logic [FRAME_W-1:0]     frame_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DIGIT_COUNT-1:0] select_reg;
    logic [7:0]             seg_reg;
    logic                   last_reg;
    logic                   advance;
    logic [7:0]             seg_raw;
    logic [7:0]             seg_new;

    // A frame moves into the result register when it is free or being taken.
    assign advance    = entry_valid && (!out_valid_reg || pop);
    assign entry_done = advance && (frame_reg == LAST_FRAME);

    assign empty        = !out_valid_reg;
    assign digit_select = select_reg;
    assign segments     = seg_reg;
    assign last_digit   = last_reg;

    // Pattern of the current frame, with its dot when flagged.
    always_comb
    begin
        seg_raw = seg_pattern(entry.idx[frame_reg]);
        seg_new = entry.dot[frame_reg] ? (seg_raw & DOT_MASK) : seg_raw;
    end

    // Frame counter and result valid flag.
    always_comb
    begin
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            frame_next     = (frame_reg == LAST_FRAME) ? '0 : frame_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            select_reg <= FIRST_SELECT >> frame_reg;
            seg_reg    <= seg_new;
            last_reg   <= (frame_reg == LAST_FRAME);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/seven_segment_time_scanner.sv @@
// Top level of the eight-digit time scanner: front end, request queue and back end.
// Path: an accepted request passes the front stage register and the queue before its first frame is registered.
// Throughput: one frame per cycle while pop is held high, eight frames per request.
// Requests enter back to back until the queue and the front stage fill up.
// The eight-frame scan sets the sustained rate: a request leaves the queue with its last frame.
// Reset (rst_n low, asynchronous) empties all stages; the result side shows empty.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_time_scanner
    import sst_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   cmd,
    input  wire logic [6:0]             hours,
    input  wire logic [5:0]             minutes,
    input  wire logic [5:0]             seconds,
    input  wire logic [9:0]             milliseconds,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [DIGIT_COUNT-1:0]      digit_select,
    output logic [7:0]                  segments,
    output logic                        last_digit
);

    logic       wr_valid;
    sst_entry_t wr_data;
    logic       wr_ready;
    sst_entry_t head_entry;
    logic       head_valid;
    logic       head_done;

    // Request intake and decimal split.
    sst_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .hours        (hours),
        .minutes      (minutes),
        .seconds      (seconds),
        .milliseconds (milliseconds),
        .wr_valid     (wr_valid),
        .wr_data      (wr_data),
        .wr_ready     (wr_ready)
    );

    // Decoupling queue.
    sst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_valid),
        .wr_data  (wr_data),
        .wr_ready (wr_ready),
        .rd_en    (head_done),
        .rd_data  (head_entry),
        .rd_valid (head_valid)
    );

    // Frame scan and result register.
    sst_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (head_entry),
        .entry_valid  (head_valid),
        .entry_done   (head_done),
        .empty        (empty),
        .pop          (pop),
        .digit_select (digit_select),
        .segments     (segments),
        .last_digit   (last_digit)
    );

endmodule

`default_nettype wire

@@ rtl/core/sst_checker.sv @@
// Port-level checker for the time scanner and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sst_checker
    import sst_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   empty,
    input wire logic                   pop,
    input wire logic [DIGIT_COUNT-1:0] digit_select,
    input wire logic [7:0]             segments,
    input wire logic                   last_digit
);

    // A shown frame selects exactly one digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $onehot(digit_select))
        else $error("digit select is not one-hot");

    // The last flag marks the rightmost digit and only that one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_digit == (digit_select == 8'h01)))
        else $error("last flag does not match the rightmost digit");

    // Within a refresh the next frame follows at once, one digit to the right.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_digit) |=>
            (!empty && (digit_select == ($past(digit_select) >> 1))))
        else $error("frames of a refresh are not contiguous");

    // A frame that is not taken stays on the result ports.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(digit_select) && $stable(segments) && $stable(last_digit)))
        else $error("waiting frame changed");

endmodule

bind seven_segment_time_scanner sst_checker u_sst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .digit_select (digit_select),
    .segments     (segments),
    .last_digit   (last_digit)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the eight-digit seven-segment time scanner.
`timescale 1ns / 1ps

module tb_top;
    import sst_pkg::*;

    localparam int GLYPH_COUNT   = 13;
    localparam int DIRECTED_ROWS = 20;
    localparam int STALL_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 20;

    // One refresh request; rows with known_frames set carry their segment bytes,
    // frame 0 in the top byte.
    typedef struct packed {
        sst_mode_t   mode;
        logic [6:0]  hrs;
        logic [5:0]  mins;
        logic [5:0]  secs;
        logic [9:0]  millis;
        logic        known_frames;
        logic [63:0] frame_segs;
    } refresh_row_t;

    // One digit frame as it leaves the block.
    typedef struct packed {
        logic [7:0] dsel;
        logic [7:0] seg;
        logic       last;
    } frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        cmd = 1'b0;
    logic [6:0]  hours = '0;
    logic [5:0]  minutes = '0;
    logic [5:0]  seconds = '0;
    logic [9:0]  milliseconds = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  digit_select;
    logic [7:0]  segments;
    logic        last_digit;

    // Side information that travels with the request on the ports.
    logic        cur_known = 1'b0;
    logic [63:0] cur_segs = '0;

    logic [7:0]     glyph [0:GLYPH_COUNT-1];
    frame_t         frames_due [$];
    refresh_row_t   script [DIRECTED_ROWS];
    frame_t         got;
    frame_t         want;
    int             error_count = 0;
    int             stall_cycles = 0;
    bit             progress;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    bit             hold_request = 1'b0;

    seven_segment_time_scanner u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .hours        (hours),
        .minutes      (minutes),
        .seconds      (seconds),
        .milliseconds (milliseconds),
        .empty        (empty),
        .pop          (pop),
        .digit_select (digit_select),
        .segments     (segments),
        .last_digit   (last_digit)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Append one expected frame; select and last flag follow from the position.
    function automatic void queue_frame(input int pos, input logic [7:0] pattern);
        frame_t fr;
        fr.dsel = FIRST_SELECT >> pos;
        fr.seg  = pattern;
        fr.last = (pos == DIGIT_COUNT - 1);
        frames_due.push_back(fr);
    endfunction

    // Work out the eight frames that one refresh request shows.
    function automatic void predict_refresh(input sst_mode_t mode, input logic [6:0] h,
                                            input logic [5:0] m, input logic [5:0] s,
                                            input logic [9:0] ms);
        int unsigned h_val;
        int unsigned m_val;
        int unsigned s_val;
        int unsigned ms_val;
        int unsigned digit;
        logic        lit_dot;
        logic [7:0]  pattern;
        h_val  = 32'(h);
        m_val  = 32'(m);
        s_val  = 32'(s);
        ms_val = 32'(ms);
        for (int pos = 0; pos < DIGIT_COUNT; pos++)
        begin
            lit_dot = 1'b0;
            if (mode == MODE_WATCH)
            begin
                // Stopwatch digits are always reduced to a single decimal digit.
                case (pos)
                    0: digit = ms_val % 10;
                    1: digit = (ms_val / 10) % 10;
                    2: digit = (ms_val / 100) % 10;
                    3: begin digit = s_val % 10; lit_dot = 1'b1; end
                    4: digit = (s_val / 10) % 10;
                    5: begin digit = m_val % 10; lit_dot = 1'b1; end
                    6: digit = (m_val / 10) % 10;
                    default: begin digit = h_val % 10; lit_dot = 1'b1; end
                endcase
            end
            else
            begin
                // Clock tens digits are not reduced, so large hours reach the
                // dash, dot and blank patterns.
                case (pos)
                    0: digit = s_val % 10;
                    1: digit = s_val / 10;
                    2: digit = 32'(DASH_INDEX);
                    3: digit = m_val % 10;
                    4: digit = m_val / 10;
                    5: digit = 32'(DASH_INDEX);
                    6: digit = h_val % 10;
                    default: digit = h_val / 10;
                endcase
            end
            pattern = glyph[digit % GLYPH_COUNT];
            if (lit_dot)
                pattern = pattern & DOT_MASK;
            queue_frame(pos, pattern);
        end
    endfunction

    // Random request, mostly with counts in their normal range.
    function automatic refresh_row_t random_request();
        refresh_row_t r;
        r = '0;
        r.mode = sst_mode_t'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < 80)
        begin
            r.hrs    = (r.mode == MODE_CLOCK) ? 7'($urandom_range(23, 0))
                                              : 7'($urandom_range(99, 0));
            r.mins   = 6'($urandom_range(59, 0));
            r.secs   = 6'($urandom_range(59, 0));
            r.millis = 10'($urandom_range(999, 0));
        end
        else
        begin
            r.hrs    = 7'($urandom);
            r.mins   = 6'($urandom);
            r.secs   = 6'($urandom);
            r.millis = 10'($urandom);
        end
        return r;
    endfunction

    // Offer one request, idling first at the current rate, and wait until it is taken.
    task automatic offer_request(input refresh_row_t row);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push         <= 1'b1;
        cmd          <= row.mode;
        hours        <= row.hrs;
        minutes      <= row.mins;
        seconds      <= row.secs;
        milliseconds <= row.millis;
        cur_known    <= row.known_frames;
        cur_segs     <= row.frame_segs;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random pop at the current rate, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            pop <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Handshake monitor: predict accepted requests, check accepted frames, watch for hangs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (push && !full)
            begin
                progress = 1'b1;
                if (cur_known)
                begin
                    for (int pos = 0; pos < DIGIT_COUNT; pos++)
                        queue_frame(pos, cur_segs[63 - 8 * pos -: 8]);
                end
                else
                    predict_refresh(sst_mode_t'(cmd), hours, minutes, seconds, milliseconds);
            end
            if (pop && !empty)
            begin
                progress = 1'b1;
                got.dsel = digit_select;
                got.seg  = segments;
                got.last = last_digit;
                if (frames_due.size() == 0)
                begin
                    $display("%0t: frame with none expected: select %h segments %h last %b",
                             $time, got.dsel, got.seg, got.last);
                    error_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.dsel !== want.dsel)
                    begin
                        $display("%0t: digit_select expected %h actual %h",
                                 $time, want.dsel, got.dsel);
                        error_count++;
                    end
                    if (got.seg !== want.seg)
                    begin
                        $display("%0t: segments expected %h actual %h",
                                 $time, want.seg, got.seg);
                        error_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: last_digit expected %b actual %b",
                                 $time, want.last, got.last);
                        error_count++;
                    end
                end
            end
            if (progress)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus: directed rows, then three random phases with different idling.
    initial
    begin
        glyph[0]  = SEG_0;
        glyph[1]  = SEG_1;
        glyph[2]  = SEG_2;
        glyph[3]  = SEG_3;
        glyph[4]  = SEG_4;
        glyph[5]  = SEG_5;
        glyph[6]  = SEG_6;
        glyph[7]  = SEG_7;
        glyph[8]  = SEG_8;
        glyph[9]  = SEG_9;
        glyph[10] = SEG_DASH;
        glyph[11] = SEG_DOT;
        glyph[12] = SEG_BLANK;

        // All zeros in both formats, then hour tens digits that show blank, dot and dash.
        script[0]  = '{MODE_CLOCK, 7'd0,   6'd0,  6'd0,  10'd0,    1'b1, 64'hc0c0bfc0c0bfc0c0};
        script[1]  = '{MODE_WATCH, 7'd0,   6'd0,  6'd0,  10'd0,    1'b1, 64'hc0c0c040c040c040};
        script[2]  = '{MODE_CLOCK, 7'd127, 6'd63, 6'd63, 10'd0,    1'b1, 64'hb082bfb082bff8ff};
        script[3]  = '{MODE_CLOCK, 7'd110, 6'd0,  6'd0,  10'd0,    1'b1, 64'hc0c0bfc0c0bfc07f};
        script[4]  = '{MODE_CLOCK, 7'd100, 6'd0,  6'd0,  10'd0,    1'b1, 64'hc0c0bfc0c0bfc0bf};
        // Extremes and mixed digits, checked by the predictor.
        script[5]  = '{MODE_CLOCK, 7'd23,  6'd59, 6'd59, 10'd999,  1'b0, 64'h0};
        script[6]  = '{MODE_WATCH, 7'd99,  6'd59, 6'd59, 10'd999,  1'b0, 64'h0};
        script[7]  = '{MODE_WATCH, 7'd127, 6'd63, 6'd63, 10'd1023, 1'b0, 64'h0};
        script[8]  = '{MODE_CLOCK, 7'd12,  6'd34, 6'd56, 10'd0,    1'b0, 64'h0};
        script[9]  = '{MODE_WATCH, 7'd7,   6'd8,  6'd9,  10'd123,  1'b0, 64'h0};
        script[10] = '{MODE_CLOCK, 7'd19,  6'd48, 6'd27, 10'd1023, 1'b0, 64'h0};
        script[11] = '{MODE_WATCH, 7'd64,  6'd32, 6'd16, 10'd512,  1'b0, 64'h0};
        script[12] = '{MODE_CLOCK, 7'd99,  6'd1,  6'd10, 10'd0,    1'b0, 64'h0};
        script[13] = '{MODE_WATCH, 7'd0,   6'd0,  6'd0,  10'd456,  1'b0, 64'h0};
        script[14] = '{MODE_CLOCK, 7'd5,   6'd50, 6'd5,  10'd0,    1'b0, 64'h0};
        script[15] = '{MODE_WATCH, 7'd123, 6'd45, 6'd6,  10'd789,  1'b0, 64'h0};
        script[16] = '{MODE_CLOCK, 7'd118, 6'd60, 6'd61, 10'd0,    1'b0, 64'h0};
        script[17] = '{MODE_CLOCK, 7'd105, 6'd2,  6'd3,  10'd0,    1'b0, 64'h0};
        script[18] = '{MODE_WATCH, 7'd1,   6'd2,  6'd3,  10'd4,    1'b0, 64'h0};
        script[19] = '{MODE_CLOCK, 7'd64,  6'd37, 6'd42, 10'd341,  1'b0, 64'h0};

        // Hold reset, then release it.
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Phase one: the sender idles less than the receiver.
        send_idle_pct = 31;
        recv_idle_pct = 73;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_request(script[i]);
        for (int i = 0; i < 115; i++)
            offer_request(random_request());

        // Phase two: the receiver idles less than the sender.
        send_idle_pct = 73;
        recv_idle_pct = 31;
        for (int i = 0; i < 115; i++)
            offer_request(random_request());

        // Phase three: no idling, opened by a long receiver hold-off so the block fills.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        for (int i = 0; i < 120; i++)
            offer_request(random_request());
        push <= 1'b0;

        // Drain the remaining frames, then keep watching for stray output.
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
